[src/expression_tokenizer_macros.svh]
// Assertion macros shared by the expression tokenizer modules.
`ifndef EXPRESSION_TOKENIZER_MACROS_SVH
`define EXPRESSION_TOKENIZER_MACROS_SVH

// Checked only while the block is out of reset.
`define EXPRTOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define EXPRTOK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/exprtok_pkg.sv]
// Types, constants and helper functions of the expression tokenizer.
package exprtok_pkg;

  // Default longest line, in characters.
  localparam int MAX_LINE_DEF = 4096;

  // Fixed field widths.
  localparam int CH_W    = 8;
  localparam int KIND_W  = 3;
  localparam int START_W = 12;
  localparam int END_W   = 13;
  localparam int SPACE_W = 13;

  // Result queue depth; must be a power of two and at least two.
  localparam int FIFO_DEPTH = 4;

  // Character codes.
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CH_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CH_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CH_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  // Token kinds as reported on the result channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_NUM   = 3'd0,
    KIND_OP    = 3'd1,
    KIND_OPEN  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_STOP  = 3'd4,
    KIND_ERR   = 3'd5
  } tok_kind_t;

  // Lexer modes, one-hot.
  typedef enum logic [4:0] {
    MODE_START  = 5'b00001,
    MODE_NUMBER = 5'b00010,
    MODE_OP     = 5'b00100,
    MODE_OPEN   = 5'b01000,
    MODE_CLOSE  = 5'b10000
  } lex_mode_t;

  // What a character does besides closing a pending token.
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ERROR = 2'd1,
    ACT_STOP  = 2'd2
  } lex_act_t;

  // One result transaction.
  typedef struct packed {
    tok_kind_t           token_kind;
    logic [START_W-1:0]  token_start;
    logic [END_W-1:0]    token_end;
    logic                last_of_run;
  } tok_t;

  // The results of one character, handed from the lexer to the queue.
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } tok_pair_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_op(input logic [CH_W-1:0] c);
    return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_PCT, CH_GT, CH_LT};
  endfunction

endpackage

[src/exprtok_if.sv]
// Channel interfaces of the expression tokenizer: characters in, tokens out.
interface exprtok_in_if;
  import exprtok_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic [CH_W-1:0] next_ch;

  modport source (output valid, ch, next_ch, input ready);
  modport sink   (input valid, ch, next_ch, output ready);
endinterface

interface exprtok_out_if;
  import exprtok_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [START_W-1:0] token_start;
  logic [END_W-1:0]   token_end;
  logic               last_of_run;

  modport source (output valid, token_kind, token_start, token_end, last_of_run, input ready);
  modport sink   (input valid, token_kind, token_start, token_end, last_of_run, output ready);
endinterface

[src/exprtok_lexer.sv]
// Lexer state and the per-character decision logic of the tokenizer.
`include "expression_tokenizer_macros.svh"

module exprtok_lexer #(
  parameter int MAX_LINE = exprtok_pkg::MAX_LINE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [exprtok_pkg::CH_W-1:0] ch,
  input  logic [exprtok_pkg::CH_W-1:0] next_ch,
  output exprtok_pkg::tok_pair_t       toks
);
  import exprtok_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE + 1);
  localparam int CMP_W = (POS_W > SPACE_W) ? POS_W : SPACE_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

  lex_mode_t          mode_r, mode_nxt;
  logic               seen_r, seen_nxt;
  logic [SPACE_W-1:0] space_r, space_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [START_W-1:0] pstart_r, pstart_nxt;
  logic               discard_r, discard_nxt;

  lex_act_t           act;
  logic               close_v;
  tok_kind_t          close_kind;
  logic               do_start;
  logic               restart;
  logic               fin_v;
  logic [POS_W-1:0]   pos_inc;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   space_ext;
  logic [CMP_W-1:0]   close_gap;
  logic [END_W-1:0]   close_end;
  logic [END_W-1:0]   pos_end;
  logic               sign_digit;
  tok_t               close_tok;
  tok_t               fin_tok;

  // Position arithmetic: saturating advance and the end of a pending token.
  assign pos_inc   = (pos_r < POS_MAX) ? pos_r + 1'b1 : POS_MAX;
  assign pos_ext   = CMP_W'(pos_r);
  assign space_ext = CMP_W'(space_r);
  assign close_gap = (space_ext <= pos_ext) ? pos_ext - space_ext : '0;
  assign close_end = END_W'(close_gap);
  assign pos_end   = END_W'(pos_ext);
  assign sign_digit = ((ch == CH_PLUS) || (ch == CH_MINUS)) && is_digit(next_ch);

  // Next state and results for the character on the input.
  always_comb begin
    act         = ACT_NONE;
    close_v     = 1'b0;
    close_kind  = KIND_NUM;
    do_start    = 1'b0;
    restart     = 1'b0;
    mode_nxt    = mode_r;
    seen_nxt    = seen_r;
    space_nxt   = space_r;
    pos_nxt     = pos_r;
    pstart_nxt  = pstart_r;
    discard_nxt = discard_r;

    if (discard_r) begin
      if (ch == CH_NUL) begin
        restart = 1'b1;
      end else begin
        pos_nxt = pos_inc;
      end
    end else begin
      if ((ch != CH_NUL) && (pos_r >= POS_MAX)) begin
        act = ACT_ERROR;
      end else if (ch == CH_SPACE) begin
        if (space_r != '1) begin
          space_nxt = space_r + 1'b1;
        end
      end else begin
        case (mode_r)
          MODE_NUMBER: begin
            if (is_digit(ch) && (space_r == '0)) begin
              // Digit extends the number.
            end else if ((ch == CH_POINT) && !seen_r && (space_r == '0) &&
                         is_digit(next_ch)) begin
              seen_nxt = 1'b1;
            end else if (is_op(ch)) begin
              close_v    = 1'b1;
              close_kind = KIND_NUM;
              mode_nxt   = MODE_OP;
              pstart_nxt = START_W'(pos_r);
              space_nxt  = '0;
            end else if (ch == CH_NUL) begin
              close_v    = 1'b1;
              close_kind = KIND_NUM;
              act        = ACT_STOP;
            end else if (ch == CH_RPAR) begin
              close_v    = 1'b1;
              close_kind = KIND_NUM;
              mode_nxt   = MODE_CLOSE;
              pstart_nxt = START_W'(pos_r);
              space_nxt  = '0;
            end else begin
              act = ACT_ERROR;
            end
          end
          MODE_OP: begin
            if ((ch == CH_EQ) && (space_r == '0)) begin
              // An equals sign extends the operator.
            end else if (is_digit(ch) || (((ch == CH_PLUS) || (ch == CH_MINUS)) &&
                         (is_digit(next_ch) || (next_ch == CH_POINT)))) begin
              close_v    = 1'b1;
              close_kind = KIND_OP;
              mode_nxt   = MODE_NUMBER;
              pstart_nxt = START_W'(pos_r);
              space_nxt  = '0;
              seen_nxt   = 1'b0;
            end else if (ch == CH_POINT) begin
              close_v    = 1'b1;
              close_kind = KIND_OP;
              mode_nxt   = MODE_NUMBER;
              pstart_nxt = START_W'(pos_r);
              space_nxt  = '0;
              seen_nxt   = 1'b1;
            end else if (ch == CH_LPAR) begin
              close_v    = 1'b1;
              close_kind = KIND_OP;
              mode_nxt   = MODE_OPEN;
              pstart_nxt = START_W'(pos_r);
              space_nxt  = '0;
            end else begin
              act = ACT_ERROR;
            end
          end
          MODE_OPEN: begin
            if (ch == CH_NUL) begin
              act = ACT_ERROR;
            end else begin
              close_v    = 1'b1;
              close_kind = KIND_OPEN;
              do_start   = 1'b1;
            end
          end
          MODE_CLOSE: begin
            if (is_digit(ch)) begin
              close_v    = 1'b1;
              close_kind = KIND_CLOSE;
              mode_nxt   = MODE_NUMBER;
              pstart_nxt = START_W'(pos_r);
              space_nxt  = '0;
              seen_nxt   = 1'b0;
            end else if ((ch == CH_POINT) && is_digit(next_ch)) begin
              close_v    = 1'b1;
              close_kind = KIND_CLOSE;
              mode_nxt   = MODE_NUMBER;
              pstart_nxt = START_W'(pos_r);
              space_nxt  = '0;
              seen_nxt   = 1'b1;
            end else if (is_op(ch)) begin
              close_v    = 1'b1;
              close_kind = KIND_CLOSE;
              mode_nxt   = MODE_OP;
              pstart_nxt = START_W'(pos_r);
              space_nxt  = '0;
            end else if (ch == CH_NUL) begin
              close_v    = 1'b1;
              close_kind = KIND_CLOSE;
              act        = ACT_STOP;
            end else if (ch == CH_LPAR) begin
              close_v    = 1'b1;
              close_kind = KIND_CLOSE;
              mode_nxt   = MODE_OPEN;
              pstart_nxt = START_W'(pos_r);
              space_nxt  = '0;
            end else begin
              act = ACT_ERROR;
            end
          end
          MODE_START: begin
            do_start = 1'b1;
          end
          default: begin
            do_start = 1'b1;
          end
        endcase

        // A character that may open a new token, from the start mode or after an open bracket.
        if (do_start) begin
          if (is_digit(ch) || sign_digit) begin
            mode_nxt   = MODE_NUMBER;
            pstart_nxt = START_W'(pos_r);
            space_nxt  = '0;
            seen_nxt   = 1'b0;
          end else if (ch == CH_NUL) begin
            act = ACT_STOP;
          end else if (ch == CH_POINT) begin
            mode_nxt   = MODE_NUMBER;
            pstart_nxt = START_W'(pos_r);
            space_nxt  = '0;
            seen_nxt   = 1'b1;
          end else if (ch == CH_LPAR) begin
            mode_nxt   = MODE_OPEN;
            pstart_nxt = START_W'(pos_r);
            space_nxt  = '0;
          end else begin
            act = ACT_ERROR;
          end
        end
      end

      // Error and stop handling, then the position advance.
      if (act == ACT_ERROR) begin
        mode_nxt   = MODE_START;
        seen_nxt   = 1'b0;
        space_nxt  = '0;
        pstart_nxt = '0;
        if (ch == CH_NUL) begin
          restart = 1'b1;
        end else begin
          discard_nxt = 1'b1;
          pos_nxt     = pos_inc;
        end
      end else if (act == ACT_STOP) begin
        restart = 1'b1;
      end else begin
        pos_nxt = pos_inc;
      end
    end

    // The terminator restarts the line.
    if (restart) begin
      mode_nxt    = MODE_START;
      seen_nxt    = 1'b0;
      space_nxt   = '0;
      pstart_nxt  = '0;
      pos_nxt     = '0;
      discard_nxt = 1'b0;
    end
  end

  // Result transactions of this character, in order.
  assign fin_v = (act != ACT_NONE);

  always_comb begin
    close_tok.token_kind  = close_kind;
    close_tok.token_start = pstart_r;
    close_tok.token_end   = close_end;
    close_tok.last_of_run = !fin_v;

    fin_tok.token_kind  = (act == ACT_STOP) ? KIND_STOP : KIND_ERR;
    fin_tok.token_start = '0;
    fin_tok.token_end   = pos_end;
    fin_tok.last_of_run = 1'b1;

    toks.count  = step ? (2'(close_v) + 2'(fin_v)) : 2'd0;
    toks.first  = close_v ? close_tok : fin_tok;
    toks.second = fin_tok;
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_START;
      seen_r    <= 1'b0;
      space_r   <= '0;
      pos_r     <= '0;
      pstart_r  <= '0;
      discard_r <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      seen_r    <= seen_nxt;
      space_r   <= space_nxt;
      pos_r     <= pos_nxt;
      pstart_r  <= pstart_nxt;
      discard_r <= discard_nxt;
    end
  end

  // While discarding, the lexer sits in its start mode and reports nothing.
  `EXPRTOK_ASSERT(a_discard_mode, discard_r |-> (mode_r == MODE_START), "discarding outside start mode")
  `EXPRTOK_ASSERT(a_discard_quiet, (step && discard_r) |-> (toks.count == 2'd0), "token while discarding")
  `EXPRTOK_ASSERT(a_pos_range, pos_r <= POS_MAX, "position beyond line limit")

endmodule

[src/exprtok_fifo.sv]
// Result queue: takes up to two tokens per character and hands out one per cycle while the output is ready.
`include "expression_tokenizer_macros.svh"

module exprtok_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  exprtok_pkg::tok_pair_t push,
  input  logic                   pop,
  output exprtok_pkg::tok_t      head,
  output logic                   head_valid,
  output logic                   room_for_two
);
  import exprtok_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  tok_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] tail_plus1;

  assign head         = mem_r[head_r];
  assign head_valid   = (count_r != '0);
  assign room_for_two = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign tail_plus1   = tail_r + 1'b1;

  // Pointer and occupancy update.
  always_comb begin
    head_nxt  = pop ? head_r + 1'b1 : head_r;
    tail_nxt  = tail_r + PTR_W'(push.count);
    count_nxt = count_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[tail_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[tail_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  `EXPRTOK_ASSERT(a_count_range, count_r <= CNT_W'(FIFO_DEPTH), "queue over capacity")
  `EXPRTOK_ASSERT(a_push_room, (push.count != 2'd0) |-> room_for_two, "push without room")
  `EXPRTOK_ASSERT(a_pair_order, (push.count == 2'd2) |-> (!push.first.last_of_run && push.second.last_of_run), "pair end marker misplaced")

endmodule

[src/expression_tokenizer.sv]
// Expression tokenizer top level: character channel in, token channel out.
//
// The block takes one character per cycle with its lookahead and reports
// zero, one or two tokens for it (number, operator, brackets, stop, error),
// each with its start and its exclusive end position. The lexer decides a
// character in the cycle it is accepted; its tokens enter a four-entry
// result queue, whose head drives the output channel, one token per cycle.
// Input is taken whenever the queue has room for two tokens, so a steady
// stream of characters moves at one per cycle while the output keeps up;
// a character that yields two tokens takes two output transfers, and a
// stalled output stops the input once three or four tokens are queued.
// An accepted character's tokens are registered in the queue before they reach the output.
module expression_tokenizer #(
  parameter int MAX_LINE = exprtok_pkg::MAX_LINE_DEF
) (
  input logic          clk,
  input logic          rst_n,
  exprtok_in_if.sink   in_chan,
  exprtok_out_if.source out_chan
);
  import exprtok_pkg::*;

  logic      step;
  logic      pop;
  logic      room_for_two;
  logic      head_valid;
  tok_pair_t toks;
  tok_t      head;

  // Handshakes.
  assign in_chan.ready = room_for_two;
  assign step          = in_chan.valid & room_for_two;
  assign pop           = head_valid & out_chan.ready;

  exprtok_lexer #(
    .MAX_LINE (MAX_LINE)
  ) u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .ch      (in_chan.ch),
    .next_ch (in_chan.next_ch),
    .toks    (toks)
  );

  exprtok_fifo u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (toks),
    .pop          (pop),
    .head         (head),
    .head_valid   (head_valid),
    .room_for_two (room_for_two)
  );

  // Output transaction.
  assign out_chan.valid       = head_valid;
  assign out_chan.token_kind  = head.token_kind;
  assign out_chan.token_start = head.token_start;
  assign out_chan.token_end   = head.token_end;
  assign out_chan.last_of_run = head.last_of_run;

endmodule

[tb/tb_exprtok_checker.sv]
`timescale 1ns / 100ps
// Token checker for the expression tokenizer: predicts tokens from characters and compares them.
module tb_exprtok_checker #(
  parameter int MAX_LINE = exprtok_pkg::MAX_LINE_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  exprtok_in_if  in_chan,
  exprtok_out_if out_chan,
  output int     mismatches,
  output int     tokens_due
);
  import exprtok_pkg::*;

  // Predicted lexer state.
  lex_mode_t          mode;
  logic               point_seen;
  logic [END_W-1:0]   blank_count;
  logic [END_W-1:0]   cursor;
  logic [START_W-1:0] tok_begin;
  logic               skipping;

  // Tokens of the current character, and tokens still owed by the block.
  tok_t step_toks[$];
  tok_t expected_tokens[$];
  tok_t want;

  int error_total = 0;
  int due_count   = 0;

  assign mismatches  = error_total;
  assign tokens_due  = due_count;

  function automatic logic digit_char(input logic [CH_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic op_char(input logic [CH_W-1:0] c);
    case (c)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_PCT, CH_GT, CH_LT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic put_tok(input tok_kind_t k, input logic [START_W-1:0] s,
                         input logic [END_W-1:0] e);
    tok_t t;
    t.token_kind  = k;
    t.token_start = s;
    t.token_end   = e;
    t.last_of_run = 1'b0;
    step_toks.push_back(t);
  endtask

  // The pending token ends where its trailing spaces begin.
  task automatic close_tok(input tok_kind_t k, input logic [END_W-1:0] pos);
    put_tok(k, tok_begin, (blank_count <= pos) ? pos - blank_count : '0);
  endtask

  task automatic open_tok(input lex_mode_t m, input logic [END_W-1:0] pos);
    mode        = m;
    tok_begin   = pos[START_W-1:0];
    blank_count = '0;
  endtask

  task automatic clear_tokens();
    mode        = MODE_START;
    point_seen  = 1'b0;
    blank_count = '0;
    tok_begin   = '0;
  endtask

  task automatic reset_lexer();
    clear_tokens();
    cursor   = '0;
    skipping = 1'b0;
  endtask

  // A character that may begin a token, from start mode or after an open bracket.
  task automatic fresh_char(input logic [CH_W-1:0] c, input logic [CH_W-1:0] nx,
                            input logic [END_W-1:0] pos, output lex_act_t act);
    act = ACT_NONE;
    if (digit_char(c) || ((c == CH_PLUS || c == CH_MINUS) && digit_char(nx))) begin
      open_tok(MODE_NUMBER, pos);
      point_seen = 1'b0;
    end else if (c == CH_NUL) begin
      act = ACT_STOP;
    end else if (c == CH_POINT) begin
      open_tok(MODE_NUMBER, pos);
      point_seen = 1'b1;
    end else if (c == CH_LPAR) begin
      open_tok(MODE_OPEN, pos);
    end else begin
      act = ACT_ERROR;
    end
  endtask

  // Work out the tokens of one accepted character and queue them.
  task automatic lex_char(input logic [CH_W-1:0] c, input logic [CH_W-1:0] nx);
    lex_act_t         act;
    logic [END_W-1:0] pos;
    logic             restart;
    tok_t             t;
    act     = ACT_NONE;
    pos     = cursor;
    restart = 1'b0;
    step_toks.delete();
    if (skipping) begin
      // After an error everything up to the terminator is dropped.
      if (c == CH_NUL) begin
        reset_lexer();
      end else if (cursor < MAX_LINE) begin
        cursor = cursor + 1'b1;
      end
    end else begin
      if (c != CH_NUL && pos >= MAX_LINE) begin
        act = ACT_ERROR;
      end else if (c == CH_SPACE) begin
        if (blank_count < {END_W{1'b1}}) blank_count = blank_count + 1'b1;
      end else begin
        case (mode)
          MODE_NUMBER: begin
            if (digit_char(c) && blank_count == 0) begin
              // The number goes on.
            end else if (c == CH_POINT && !point_seen && blank_count == 0 &&
                         digit_char(nx)) begin
              point_seen = 1'b1;
            end else if (op_char(c)) begin
              close_tok(KIND_NUM, pos);
              open_tok(MODE_OP, pos);
            end else if (c == CH_NUL) begin
              close_tok(KIND_NUM, pos);
              act = ACT_STOP;
            end else if (c == CH_RPAR) begin
              close_tok(KIND_NUM, pos);
              open_tok(MODE_CLOSE, pos);
            end else begin
              act = ACT_ERROR;
            end
          end
          MODE_OP: begin
            if (c == CH_EQ && blank_count == 0) begin
              // An equals sign extends the operator.
            end else if (digit_char(c) || ((c == CH_PLUS || c == CH_MINUS) &&
                                           (digit_char(nx) || nx == CH_POINT))) begin
              close_tok(KIND_OP, pos);
              open_tok(MODE_NUMBER, pos);
              point_seen = 1'b0;
            end else if (c == CH_POINT) begin
              close_tok(KIND_OP, pos);
              open_tok(MODE_NUMBER, pos);
              point_seen = 1'b1;
            end else if (c == CH_LPAR) begin
              close_tok(KIND_OP, pos);
              open_tok(MODE_OPEN, pos);
            end else begin
              act = ACT_ERROR;
            end
          end
          MODE_OPEN: begin
            if (c == CH_NUL) begin
              act = ACT_ERROR;
            end else begin
              close_tok(KIND_OPEN, pos);
              fresh_char(c, nx, pos, act);
            end
          end
          MODE_CLOSE: begin
            if (digit_char(c)) begin
              close_tok(KIND_CLOSE, pos);
              open_tok(MODE_NUMBER, pos);
              point_seen = 1'b0;
            end else if (c == CH_POINT && digit_char(nx)) begin
              close_tok(KIND_CLOSE, pos);
              open_tok(MODE_NUMBER, pos);
              point_seen = 1'b1;
            end else if (op_char(c)) begin
              close_tok(KIND_CLOSE, pos);
              open_tok(MODE_OP, pos);
            end else if (c == CH_NUL) begin
              close_tok(KIND_CLOSE, pos);
              act = ACT_STOP;
            end else if (c == CH_LPAR) begin
              close_tok(KIND_CLOSE, pos);
              open_tok(MODE_OPEN, pos);
            end else begin
              act = ACT_ERROR;
            end
          end
          default: fresh_char(c, nx, pos, act);
        endcase
      end

      // Error and stop come after any token that the character closed.
      if (act == ACT_ERROR) begin
        put_tok(KIND_ERR, '0, pos);
        clear_tokens();
        if (c == CH_NUL) restart = 1'b1;
        else skipping = 1'b1;
      end else if (act == ACT_STOP) begin
        put_tok(KIND_STOP, '0, pos);
        restart = 1'b1;
      end

      if (restart) begin
        reset_lexer();
      end else if (pos < MAX_LINE) begin
        cursor = pos + 1'b1;
      end else begin
        cursor = END_W'(MAX_LINE);
      end

      foreach (step_toks[i]) begin
        t = step_toks[i];
        t.last_of_run = (i == step_toks.size() - 1);
        expected_tokens.push_back(t);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [END_W-1:0] exp_val,
                               input logic [END_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      error_total++;
    end
  endtask

  // Predict on each character transaction, compare on each token transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_lexer();
      expected_tokens.delete();
    end else begin
      if (in_chan.valid && in_chan.ready) lex_char(in_chan.ch, in_chan.next_ch);
      if (out_chan.valid && out_chan.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token with no expectation waiting: kind %0d start %0d end %0d",
                 out_chan.token_kind, out_chan.token_start, out_chan.token_end);
          error_total++;
        end else begin
          want = expected_tokens.pop_front();
          compare_field("token_kind", END_W'(want.token_kind), END_W'(out_chan.token_kind));
          compare_field("token_start", END_W'(want.token_start), END_W'(out_chan.token_start));
          compare_field("token_end", want.token_end, out_chan.token_end);
          compare_field("last_of_run", END_W'(want.last_of_run), END_W'(out_chan.last_of_run));
        end
      end
    end
    due_count = expected_tokens.size();
  end

endmodule

[tb/tb_expression_tokenizer.sv]
`timescale 1ns / 100ps
// Testbench top of the expression tokenizer: clock, reset, character stimulus and verdict.
module tb_expression_tokenizer;
  import exprtok_pkg::*;

  localparam int RANDOM_CHARS = 1300;
  localparam int HOLD_CYCLES  = 80;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Idle control for the sender and for the receiver.
  logic in_quiet  = 1'b0;
  logic out_quiet = 1'b0;
  logic hold_req  = 1'b0;

  int mismatches;
  int tokens_due;
  int chars_sent = 0;

  logic [CH_W-1:0] line_buf[$];

  exprtok_in_if  in_chan ();
  exprtok_out_if out_chan ();

  expression_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tb_exprtok_checker #(.MAX_LINE(MAX_LINE_DEF)) u_token_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .mismatches  (mismatches),
    .tokens_due  (tokens_due)
  );

  always #1 clk = ~clk;

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_expression_tokenizer: errors");
    $finish;
  end

  // Token receiver: random stalls, and one long hold-off when asked for.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_chan.ready <= out_quiet || ($urandom_range(99) >= 22);
    end
  end

  function automatic logic [CH_W-1:0] pick_op();
    case ($urandom_range(7))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      3: return CH_SLASH;
      4: return CH_CARET;
      5: return CH_PCT;
      6: return CH_GT;
      default: return CH_LT;
    endcase
  endfunction

  // Any character, weighted toward the ones the lexer knows.
  function automatic logic [CH_W-1:0] any_char();
    case ($urandom_range(11))
      0: return CH_NUL;
      1: return CH_SPACE;
      2: return CH_EQ;
      3: return CH_POINT;
      4: return CH_LPAR;
      5: return CH_RPAR;
      6, 7: return pick_op();
      8, 9: return CH_W'(CH_ZERO + $urandom_range(9));
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  // Offer one character transaction, with a random gap before it.
  task automatic send_char(input logic [CH_W-1:0] c, input logic [CH_W-1:0] nx);
    while (!in_quiet && $urandom_range(99) < 22) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.ch      <= c;
    in_chan.next_ch <= nx;
    do @(posedge clk); while (!in_chan.ready);
    chars_sent++;
    @(negedge clk);
  endtask

  // Send the buffered line, each character with the one after it as lookahead.
  task automatic send_line();
    logic [CH_W-1:0] nx;
    for (int i = 0; i < line_buf.size(); i++) begin
      nx = (i + 1 < line_buf.size()) ? line_buf[i+1] : CH_W'($urandom_range(255));
      send_char(line_buf[i], nx);
    end
    line_buf.delete();
  endtask

  // Stop sending until every predicted token has come out.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (tokens_due == 0);
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic push_digits(input int n);
    repeat (n) line_buf.push_back(CH_W'(CH_ZERO + $urandom_range(9)));
  endtask

  task automatic push_blanks();
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SPACE);
  endtask

  task automatic push_op();
    line_buf.push_back(pick_op());
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(CH_EQ);
  endtask

  // A number with optional sign and point; a sign before a point only after an operator.
  task automatic push_number(input bit after_op);
    bit signed_num;
    signed_num = ($urandom_range(3) == 0);
    if (signed_num) line_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
    if ((!signed_num || after_op) && $urandom_range(6) == 0) begin
      line_buf.push_back(CH_POINT);
      push_digits($urandom_range(1, 3));
    end else begin
      push_digits($urandom_range(1, 4));
      if ($urandom_range(3) == 0) begin
        line_buf.push_back(CH_POINT);
        push_digits($urandom_range(1, 3));
      end
    end
  endtask

  // A well-formed expression with brackets and spaces, ended by the terminator.
  task automatic build_expr();
    int depth;
    int terms;
    bit opened;
    depth = 0;
    terms = $urandom_range(1, 6);
    push_blanks();
    for (int t = 0; t < terms; t++) begin
      opened = 1'b0;
      if (t > 0) begin
        push_op();
        push_blanks();
      end
      while (depth < 3 && $urandom_range(3) == 0) begin
        line_buf.push_back(CH_LPAR);
        depth++;
        opened = 1'b1;
        push_blanks();
      end
      push_number(t > 0 && !opened);
      push_blanks();
      while (depth > 0 && $urandom_range(2) == 0) begin
        line_buf.push_back(CH_RPAR);
        depth--;
        case ($urandom_range(7))
          // A close bracket right before an open bracket.
          0: begin
            line_buf.push_back(CH_LPAR);
            depth++;
            push_number(1'b0);
          end
          // A number with a leading point straight after a close bracket.
          1: begin
            line_buf.push_back(CH_POINT);
            push_digits($urandom_range(1, 2));
          end
          default: ;
        endcase
        push_blanks();
      end
    end
    repeat (depth) line_buf.push_back(CH_RPAR);
    push_blanks();
    line_buf.push_back(CH_NUL);
  endtask

  // Stimulus and verdict.
  initial begin
    int lines;
    int base;
    in_chan.valid   = 1'b0;
    in_chan.ch      = '0;
    in_chan.next_ch = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every operator, brackets back to back, signed and pointed numbers.
    push_text("(1)(.5)/3%-4>=5<6^7*8+9");
    line_buf.push_back(CH_NUL);
    send_line();
    // A space inside a number, then a discarded all-ones byte.
    push_text("1 2");
    send_line();
    send_char(8'hFF, 8'hFF);
    line_buf.push_back(CH_NUL);
    send_line();
    // Terminator right after an open bracket, and right after an operator.
    push_text("(");
    line_buf.push_back(CH_NUL);
    push_text("5+");
    line_buf.push_back(CH_NUL);
    send_line();
    drain();

    // Random: mostly well-formed lines, some broken ones and some noise.
    base  = chars_sent;
    lines = 0;
    while (chars_sent - base < RANDOM_CHARS) begin
      lines++;
      if (lines == 8) hold_req = 1'b1;
      if (lines == 20) begin
        drain();
        in_quiet  = 1'b1;
        out_quiet = 1'b1;
      end
      if (lines == 35) begin
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
      end
      case ($urandom_range(99)) inside
        [0:71]: build_expr();
        [72:87]: begin
          build_expr();
          repeat ($urandom_range(1, 2)) line_buf[$urandom_range(line_buf.size() - 1)] = any_char();
        end
        default: begin
          repeat ($urandom_range(1, 10)) line_buf.push_back(any_char());
          if ($urandom_range(1)) line_buf.push_back(CH_NUL);
        end
      endcase
      send_line();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_expression_tokenizer: clean");
    end else begin
      $display("tb_expression_tokenizer: errors");
    end
    $finish;
  end

endmodule
